@@ rtl/qwcos_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants, types and the elaboration-time cosine table builder
// for the quarter-wave cosine lookup core. No dependencies.
package qwcos_pkg;

    // Configuration of the lookup
    localparam int TABLE_ENTRIES   = 1024;
    localparam int ANGLE_FRAC_BITS = 16;
    localparam int OUT_FRAC_BITS   = 15;

    // Fixed payload widths
    localparam int ANGLE_W = 32;
    localparam int COS_W   = 16;

    // Derived widths
    localparam int MAG_W  = ANGLE_W - 1;
    localparam int CONV_W = 32;
    localparam int PROD_W = MAG_W + CONV_W;
    localparam int FRAC_W = 32;
    localparam int OPND_W = FRAC_W + 1;
    localparam int IDX_W  = $clog2(TABLE_ENTRIES + 1);
    localparam int SCL_W  = OPND_W + IDX_W;
    localparam int ENT_W  = OUT_FRAC_BITS;
    localparam int VAL_W  = (OUT_FRAC_BITS + 1 > COS_W) ? OUT_FRAC_BITS + 1 : COS_W;

    // 2/pi in unsigned Q0.32, pi/2 in Q32
    localparam logic [CONV_W-1:0] TWO_OVER_PI_Q32 = 32'hA2F9836E;
    localparam logic [63:0]       HALF_PI_Q32     = 64'h0000_0001_921F_B544;

    // Taylor divisors (2k-1)(2k) for terms one through twelve
    localparam logic [63:0] TAYLOR_DIV [1:12] = '{
        64'd2,   64'd12,  64'd30,  64'd56,  64'd90,  64'd132,
        64'd182, 64'd240, 64'd306, 64'd380, 64'd462, 64'd552
    };

    typedef logic [ENT_W-1:0] rom_t [0:TABLE_ENTRIES];

    // Table lookup request: entry index and sign flag
    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic             neg;
    } lookup_t;

    // Table read result travelling to the output stage
    typedef struct packed {
        logic [ENT_W-1:0] ent;
        logic             neg;
    } rom_out_t;

    function automatic logic [ENT_W-1:0] cos_entry(input int unsigned i);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic signed [63:0] c;
        logic signed [63:0] maxv;
        logic [ENT_W-1:0]   res;
        int                 k;
        x    = ((HALF_PI_Q32 * 64'(i)) / 64'(TABLE_ENTRIES) + 64'd2) >> 2;
        x2   = (x * x) >> 30;
        term = 64'd1 << 30;
        sum  = signed'(term);
        maxv = (64'sd1 <<< OUT_FRAC_BITS) - 64'sd1;
        for (k = 1; k <= 12; k++)
        begin
            term = ((term * x2) >> 30) / TAYLOR_DIV[k];
            if (k[0])
                sum = sum - signed'(term);
            else
                sum = sum + signed'(term);
        end
        if (sum < 0)
            res = '0;
        else
        begin
            c = (sum + (64'sd1 <<< (29 - OUT_FRAC_BITS))) >>> (30 - OUT_FRAC_BITS);
            if (c > maxv)
                c = maxv;
            res = ENT_W'(c);
        end
        return res;
    endfunction

    function automatic rom_t build_rom();
        rom_t r;
        int   i;
        for (i = 0; i <= TABLE_ENTRIES; i++)
        begin
            r[i] = cos_entry(i);
        end
        return r;
    endfunction

endpackage

@@ rtl/qwcos_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces for angle requests and cosine results.
// Depends on qwcos_pkg for payload widths.
interface qwcos_angle_if;
    import qwcos_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [ANGLE_W-1:0] angle;

    modport source (output valid, output angle, input ready);
    modport sink   (input valid, input angle, output ready);
endinterface

interface qwcos_cosine_if;
    import qwcos_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [COS_W-1:0] cosine;

    modport source (output valid, output cosine, input ready);
    modport sink   (input valid, input cosine, output ready);
endinterface

@@ rtl/quarter_wave_cosine_lookup_core.sv @@
`timescale 1ns / 1ps
// Quarter-wave cosine lookup core: top level. Depends on qwcos_pkg, qwcos_if,
// qwcos_reduce and qwcos_rom.
// Registers in order: magnitude, quarter-turn product, folded index, table read, output.
// Throughput: one request per cycle unless the output stalls; the 31x32 quarter-turn
// multiply and the registered table read each own a stage, so every stage is a single step.
// Reset: clears the stage valid bits only; the table is constant, no clearing pass.
module quarter_wave_cosine_lookup_core (
    input  logic            clk,
    input  logic            rst_n,
    qwcos_angle_if.sink     angle_ch,
    qwcos_cosine_if.source  cosine_ch
);
    import qwcos_pkg::*;

    // Stages 1-3: magnitude, quarter-turn product, folded index
    logic     lk_valid;
    logic     lk_ready;
    lookup_t  lk;

    // Stage 4: table read
    logic     rd_valid;
    logic     rd_ready;
    rom_out_t rd;

    // Stage 5: sign and output register
    logic                    out_valid_reg;
    logic [COS_W-1:0]        cos_reg, cos_next;
    logic signed [VAL_W-1:0] mag_val;
    logic signed [VAL_W-1:0] signed_val;
    logic                    en_out;

    qwcos_reduce u_reduce (
        .clk      (clk),
        .rst_n    (rst_n),
        .angle_ch (angle_ch),
        .lk_valid (lk_valid),
        .lk_ready (lk_ready),
        .lk       (lk)
    );

    qwcos_rom u_rom (
        .clk      (clk),
        .rst_n    (rst_n),
        .lk_valid (lk_valid),
        .lk_ready (lk_ready),
        .lk       (lk),
        .rd_valid (rd_valid),
        .rd_ready (rd_ready),
        .rd       (rd)
    );

    // The output register takes a new result whenever it is empty or being drained;
    // while a result waits here, every full stage behind it holds.
    assign en_out   = !out_valid_reg || cosine_ch.ready;
    assign rd_ready = en_out;

    // Negate in the second and third quadrants, then truncate to the field width
    always_comb
    begin
        mag_val = signed'(VAL_W'(rd.ent));
        if (rd.neg)
            signed_val = -mag_val;
        else
            signed_val = mag_val;
        cos_next = signed_val[COS_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en_out)
            out_valid_reg <= rd_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en_out)
            cos_reg <= cos_next;
    end

    assign cosine_ch.valid  = out_valid_reg;
    assign cosine_ch.cosine = signed'(cos_reg);

    // A request handed to the table stage must show up there on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        lk_valid && lk_ready |=> rd_valid)
        else $error("table stage dropped a request");

    // A stalled table read must hold its data
    assert property (@(posedge clk) disable iff (!rst_n)
        rd_valid && !rd_ready |=> rd_valid && $stable(rd))
        else $error("table read changed while stalled");

    // Table values never reach 1.0, so the negated range stops short of -1.0
    assert property (@(posedge clk) disable iff (!rst_n)
        cosine_ch.valid |-> (OUT_FRAC_BITS != 15) || (cosine_ch.cosine != -16'sd32768))
        else $error("cosine result out of range");

endmodule

@@ rtl/qwcos_reduce.sv @@
`timescale 1ns / 1ps
// Angle reduction pipeline: magnitude, scale to quarter turns, fold to a table index.
// Depends on qwcos_pkg and qwcos_angle_if.
module qwcos_reduce (
    input  logic               clk,
    input  logic               rst_n,
    qwcos_angle_if.sink        angle_ch,
    output logic               lk_valid,
    input  logic               lk_ready,
    output qwcos_pkg::lookup_t lk
);
    import qwcos_pkg::*;

    localparam logic [ANGLE_W-1:0] ANGLE_MIN = {1'b1, {(ANGLE_W-1){1'b0}}};
    localparam logic [OPND_W-1:0]  ONE_TURN  = {1'b1, {FRAC_W{1'b0}}};

    logic              v1_reg, v2_reg, v3_reg;
    logic              en1, en2, en3;

    logic [MAG_W-1:0]  mag_reg, mag_next;
    logic [1:0]        q_reg, q_next;
    logic [FRAC_W-1:0] g_reg, g_next;
    lookup_t           lk_reg, lk_next;

    logic [ANGLE_W-1:0] neg_angle;
    logic [PROD_W-1:0]  prod;
    logic [OPND_W-1:0]  opnd;
    logic [SCL_W-1:0]   scaled;
    logic [IDX_W-1:0]   idx_raw;

    // Advance a stage when it is empty or its contents move on
    assign en3 = !v3_reg || lk_ready;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign angle_ch.ready = en1;

    // Stage 1: absolute value, most negative saturates
    always_comb
    begin
        neg_angle = ANGLE_W'(-angle_ch.angle);
        if (!angle_ch.angle[ANGLE_W-1])
            mag_next = angle_ch.angle[MAG_W-1:0];
        else if (angle_ch.angle == ANGLE_MIN)
            mag_next = '1;
        else
            mag_next = neg_angle[MAG_W-1:0];
    end

    // Stage 2: quarter turns = |angle| * 2/pi
    always_comb
    begin
        prod   = PROD_W'(mag_reg) * PROD_W'(TWO_OVER_PI_Q32);
        q_next = prod[ANGLE_FRAC_BITS + FRAC_W +: 2];
        g_next = prod[ANGLE_FRAC_BITS +: FRAC_W];
    end

    // Stage 3: fold into the first quadrant and scale to an index
    always_comb
    begin
        if (q_reg[0])
            opnd = ONE_TURN - OPND_W'(g_reg);
        else
            opnd = OPND_W'(g_reg);
        scaled  = SCL_W'(opnd) * SCL_W'(TABLE_ENTRIES);
        idx_raw = scaled[FRAC_W +: IDX_W];
        if (idx_raw > IDX_W'(TABLE_ENTRIES))
            lk_next.idx = IDX_W'(TABLE_ENTRIES);
        else
            lk_next.idx = idx_raw;
        lk_next.neg = q_reg[0] ^ q_reg[1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                v1_reg <= angle_ch.valid;
            if (en2)
                v2_reg <= v1_reg;
            if (en3)
                v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
            mag_reg <= mag_next;
        if (en2)
        begin
            q_reg <= q_next;
            g_reg <= g_next;
        end
        if (en3)
            lk_reg <= lk_next;
    end

    assign lk_valid = v3_reg;
    assign lk       = lk_reg;

endmodule

@@ rtl/qwcos_rom.sv @@
`timescale 1ns / 1ps
// Quarter-wave cosine table with registered read, one pipeline stage.
// Depends on qwcos_pkg (table contents built at elaboration).
module qwcos_rom (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                lk_valid,
    output logic                lk_ready,
    input  qwcos_pkg::lookup_t  lk,
    output logic                rd_valid,
    input  logic                rd_ready,
    output qwcos_pkg::rom_out_t rd
);
    import qwcos_pkg::*;

    localparam rom_t ROM_TABLE = build_rom();

    logic     v_reg;
    logic     en;
    rom_out_t rd_reg;

    assign en       = !v_reg || rd_ready;
    assign lk_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (en)
            v_reg <= lk_valid;
    end

    // Hold the read data while stalled
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rd_reg.ent <= ROM_TABLE[lk.idx];
            rd_reg.neg <= lk.neg;
        end
    end

    assign rd_valid = v_reg;
    assign rd       = rd_reg;

endmodule
